>>> rtl/awb_pkg.sv
// Shared types and constants for the associative write buffer.
package awb_pkg;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 16;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_READ   = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic              hit;
		logic              dropped;
		logic              mem_write_valid;
		logic [ADDR_W-1:0] mem_write_address;
		logic [DATA_W-1:0] mem_write_data;
		logic              last;
	} res_t;

endpackage

>>> rtl/awb_mem.sv
// Slot storage: address and value per slot, one write and one registered read per cycle.
module awb_mem #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  awb_pkg::entry_t       wr_data,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_idx,
	output awb_pkg::entry_t       rd_data
);
	import awb_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/awb_seq.sv
// Sequencer: walks the slots with one shared address compare and drives the memory.
module awb_seq #(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [awb_pkg::OP_W-1:0]      operation,
	input  logic [awb_pkg::ADDR_W-1:0]    address,
	input  logic [awb_pkg::DATA_W-1:0]    write_value,
	output logic                          busy,
	input  logic                          can_push,
	output logic                          push,
	output awb_pkg::res_t                 res
);
	import awb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_CMP,
		ST_FIN,
		ST_CLOOK,
		ST_CEMIT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [ENTRIES-1:0] valid_q;
	logic [OP_W-1:0]    op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [DATA_W-1:0]  wval_q;
	logic [DATA_W-1:0]  rval_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic               rd_en;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_data;
	entry_t             rd_data;
	logic [ENTRIES-1:0] others;

	awb_mem #(
		.DEPTH (ENTRIES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_idx  (cnt_q),
		.rd_data (rd_data)
	);

	assign busy   = (state_q != ST_IDLE);
	assign others = valid_q & ~(ENTRIES'(1) << cnt_q);

	always_comb begin
		rd_en = ((state_q == ST_LOOK) || (state_q == ST_CLOOK)) && valid_q[cnt_q];
		wr_en = (state_q == ST_FIN) && can_push && (op_q == OP_WRITE) && (hit_q || free_q);
		wr_idx = hit_q ? hit_idx_q : free_idx_q;
		wr_data.addr  = addr_q;
		wr_data.value = wval_q;
	end

	always_comb begin
		push = 1'b0;
		res  = '0;
		unique case (state_q)
			ST_FIN: begin
				push     = can_push;
				res.last = 1'b1;
				case (op_q)
					OP_READ: begin
						res.hit        = hit_q;
						res.read_value = hit_q ? rval_q : '0;
					end
					OP_WRITE: begin
						res.hit     = hit_q;
						res.dropped = !hit_q && !free_q;
					end
					default: ;
				endcase
			end
			ST_CEMIT: begin
				push                  = can_push;
				res.mem_write_valid   = 1'b1;
				res.mem_write_address = rd_data.addr;
				res.mem_write_data    = rd_data.value;
				res.last              = (others == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			valid_q    <= '0;
			op_q       <= OP_READ;
			addr_q     <= '0;
			wval_q     <= '0;
			rval_q     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= operation;
						addr_q <= address;
						wval_q <= write_value;
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						case (operation) inside
							OP_READ, OP_WRITE: state_q <= ST_LOOK;
							OP_COMMIT:         state_q <= (valid_q == '0) ? ST_FIN : ST_CLOOK;
							default:           state_q <= ST_FIN;
						endcase
					end
				end
				ST_LOOK: begin
					if (valid_q[cnt_q]) begin
						state_q <= ST_CMP;
					end else begin
						if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cnt_q;
						end
						if (cnt_q == LAST_IDX) begin
							state_q <= ST_FIN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_CMP: begin
					if (rd_data.addr == addr_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cnt_q;
						rval_q    <= rd_data.value;
						state_q   <= ST_FIN;
					end else if (cnt_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_FIN: begin
					if (can_push) begin
						if ((op_q == OP_WRITE) && !hit_q && free_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CLOOK: begin
					if (valid_q == '0) begin
						state_q <= ST_IDLE;
					end else if (valid_q[cnt_q]) begin
						state_q <= ST_CEMIT;
					end else if (cnt_q != LAST_IDX) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CEMIT: begin
					if (can_push) begin
						valid_q[cnt_q] <= 1'b0;
						if (cnt_q != LAST_IDX) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= (others == '0) ? ST_IDLE : ST_CLOOK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/associative_write_buffer_top.sv
// Top level of the associative write buffer: sequencer plus output word register.
//
//  channel | dir | handshake           | words carried
//  in      | in  | in_valid, in_stall   | operation, address, write_value
//  out     | out | out_valid, out_stall | read_value, hit, dropped, mem_write_*, last
//
// Read or write: each valid slot costs a memory read and a compare on the single
// comparator, each free slot a step of its own, and a hit ends the scan early.
// Commit: walks the slots, emits one word per valid slot, then goes idle.
// in_stall is high while an item is in work; a stalled output holds the sequencer.
// Reset clears all slot valid bits; slot contents are never read before written.
module associative_write_buffer_top #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [awb_pkg::OP_W-1:0]      operation,
	input  logic [awb_pkg::ADDR_W-1:0]    address,
	input  logic [awb_pkg::DATA_W-1:0]    write_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [awb_pkg::DATA_W-1:0]    read_value,
	output logic                          hit,
	output logic                          dropped,
	output logic                          mem_write_valid,
	output logic [awb_pkg::ADDR_W-1:0]    mem_write_address,
	output logic [awb_pkg::DATA_W-1:0]    mem_write_data,
	output logic                          last
);
	import awb_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic busy;
	logic can_push;
	logic push;
	res_t res;
	res_t out_q;
	logic out_valid_q;

	assign in_stall = busy;
	assign can_push = !out_valid_q || !out_stall;

	awb_seq #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid && !busy),
		.operation   (operation),
		.address     (address),
		.write_value (write_value),
		.busy        (busy),
		.can_push    (can_push),
		.push        (push),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_value        = out_q.read_value;
	assign hit               = out_q.hit;
	assign dropped           = out_q.dropped;
	assign mem_write_valid   = out_q.mem_write_valid;
	assign mem_write_address = out_q.mem_write_address;
	assign mem_write_data    = out_q.mem_write_data;
	assign last              = out_q.last;

endmodule

>>> dv/associative_write_buffer_top_tb.sv
// Testbench for the associative write buffer: slot-table scoreboard, directed and random words.
`timescale 1ns / 100ps

module associative_write_buffer_top_tb;
	import awb_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_CYCLES = 400;
	localparam int POOL_SIZE = 24;

	class write_buffer_scoreboard;
		logic [ADDR_W-1:0] slot_addr[SLOTS];
		logic [DATA_W-1:0] slot_value[SLOTS];
		bit slot_used[SLOTS];
		res_t expected_words[$];
		int errors;

		function void accept_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
				logic [DATA_W-1:0] value);
			res_t r;
			int found;
			int free_slot;
			int used_count;
			int emitted;
			r = '0;
			r.last = 1'b1;
			found = -1;
			free_slot = -1;
			used_count = 0;
			emitted = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && slot_addr[i] == addr && found < 0)
					found = i;
				if (!slot_used[i] && free_slot < 0)
					free_slot = i;
				if (slot_used[i])
					used_count++;
			end
			case (op)
				OP_READ: begin
					if (found >= 0) begin
						r.hit = 1'b1;
						r.read_value = slot_value[found];
					end
					expected_words.push_back(r);
				end
				OP_WRITE: begin
					if (found >= 0) begin
						slot_value[found] = value;
						r.hit = 1'b1;
					end else if (free_slot >= 0) begin
						slot_used[free_slot] = 1'b1;
						slot_addr[free_slot] = addr;
						slot_value[free_slot] = value;
					end else begin
						r.dropped = 1'b1;
					end
					expected_words.push_back(r);
				end
				OP_COMMIT: begin
					if (used_count == 0)
						expected_words.push_back(r);
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_used[i]) begin
							r = '0;
							r.mem_write_valid = 1'b1;
							r.mem_write_address = slot_addr[i];
							r.mem_write_data = slot_value[i];
							r.last = (emitted + 1 == used_count);
							expected_words.push_back(r);
							emitted++;
							slot_used[i] = 1'b0;
						end
					end
				end
				default: begin
					expected_words.push_back(r);
				end
			endcase
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_response(res_t got);
			res_t want;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %p", $time, got);
				return;
			end
			want = expected_words.pop_front();
			check_field("read_value", want.read_value, got.read_value);
			check_field("hit", want.hit, got.hit);
			check_field("dropped", want.dropped, got.dropped);
			check_field("mem_write_valid", want.mem_write_valid, got.mem_write_valid);
			check_field("mem_write_address", want.mem_write_address, got.mem_write_address);
			check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] operation = OP_READ;
	logic [ADDR_W-1:0] address = '0;
	logic [DATA_W-1:0] write_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DATA_W-1:0] read_value;
	logic hit;
	logic dropped;
	logic mem_write_valid;
	logic [ADDR_W-1:0] mem_write_address;
	logic [DATA_W-1:0] mem_write_data;
	logic last;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;
	logic [ADDR_W-1:0] address_pool[POOL_SIZE];
	write_buffer_scoreboard buffer_sb = new;

	associative_write_buffer_top #(.ENTRIES(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.address(address),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.hit(hit),
		.dropped(dropped),
		.mem_write_valid(mem_write_valid),
		.mem_write_address(mem_write_address),
		.mem_write_data(mem_write_data),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				buffer_sb.accept_request(operation, address, write_value);
			if (out_valid && !out_stall)
				buffer_sb.check_response(res_t'({read_value, hit, dropped, mem_write_valid,
					mem_write_address, mem_write_data, last}));
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_word(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] value);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		write_value <= value;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic run_random(int count);
		logic [OP_W-1:0] op;
		logic [ADDR_W-1:0] addr;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				op = OP_WRITE;
			else if (pick < 92)
				op = OP_READ;
			else if (pick < 97)
				op = OP_COMMIT;
			else
				op = OP_UNUSED;
			if ($urandom_range(0, 3) == 0)
				addr = ADDR_W'($urandom);
			else
				addr = address_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_word(op, addr, DATA_W'($urandom));
		end
	endtask

	initial begin
		address_pool[0] = '0;
		address_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			address_pool[i] = ADDR_W'($urandom);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty buffer, unused opcode, extremes, update, full buffer, full commit
		send_word(OP_COMMIT, 16'h0000, 16'h0000);
		send_word(OP_READ, 16'hFFFF, 16'h0000);
		send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF);
		send_word(OP_WRITE, 16'h0000, 16'hFFFF);
		send_word(OP_WRITE, 16'hFFFF, 16'h0000);
		send_word(OP_READ, 16'h0000, 16'h0000);
		send_word(OP_WRITE, 16'h0000, 16'h1234);
		send_word(OP_READ, 16'h0000, 16'hFFFF);
		for (int i = 2; i < SLOTS; i++)
			send_word(OP_WRITE, 16'h0100 + ADDR_W'(i), DATA_W'($urandom));
		send_word(OP_WRITE, 16'hABCD, 16'h5555);
		send_word(OP_WRITE, 16'hFFFF, 16'hAAAA);
		send_word(OP_COMMIT, 16'hFFFF, 16'hFFFF);
		send_word(OP_READ, 16'hFFFF, 16'h0000);

		run_random(45);
		send_idle_pct = 87;
		run_random(45);
		send_idle_pct = 0;
		recv_stall_pct = 87;
		run_random(45);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		run_random(45);

		// long output hold-off while words keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		run_random(25);

		@(negedge clk);
		in_valid <= 1'b0;
		while (buffer_sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 20) @(posedge clk);

		if (buffer_sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
